FILE: hdl/led_pkg.sv
`timescale 1ns / 1ps

package led_pkg;

  localparam int BUF_DEPTH = 32;
  localparam int CNT_W     = $clog2(BUF_DEPTH);
  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 2;
  localparam int LEN_W     = 5;
  localparam int CAP_W     = 6;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);
  localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);
  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(BUF_DEPTH);

  localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

  localparam logic [BYTE_W-1:0] CH_BS  = 8'd8;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'd13;
  localparam logic [BYTE_W-1:0] CH_SP  = 8'd32;
  localparam logic [BYTE_W-1:0] CH_DEL = 8'd127;

  typedef struct packed {
    logic accept;
    logic echo_emit;
    logic rd_issue;
    logic char_emit;
    logic done_emit;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic echo_any;
    logic echo_last;
    logic line_end;
    logic rd_done;
  } sts_t;

endpackage

FILE: hdl/led_ram.sv
`timescale 1ns / 1ps

module led_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/led_ctrl.sv
`timescale 1ns / 1ps

module led_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  led_pkg::sts_t sts_i,
  output led_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_ECHO   = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts_i.echo_any) begin
          state_d = ST_ECHO;
        end else if (sts_i.line_end) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ECHO: begin
        if (sts_i.slot_free) begin
          cmd_o.echo_emit = 1'b1;
          if (sts_i.echo_last) begin
            state_d = sts_i.line_end ? ST_READ : ST_IDLE;
          end
        end
      end
      ST_READ: begin
        if (sts_i.rd_done) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d        = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.slot_free) begin
          cmd_o.char_emit = 1'b1;
          state_d         = ST_READ;
        end
      end
      ST_DONE: begin
        if (sts_i.slot_free) begin
          cmd_o.done_emit = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

FILE: hdl/led_dp.sv
`timescale 1ns / 1ps

module led_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [led_pkg::BYTE_W-1:0]     rx_byte_i,
  input  logic                           cfg_we_i,
  input  logic [led_pkg::CAP_W-1:0]      cfg_wdata_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [led_pkg::KIND_W-1:0]     out_kind_o,
  output logic [led_pkg::BYTE_W-1:0]     out_byte_o,
  output logic [led_pkg::LEN_W-1:0]      line_length_o,
  output logic                           last_of_run_o,
  input  led_pkg::cmd_t                  cmd_i,
  output led_pkg::sts_t                  sts_o
);

  logic [led_pkg::BYTE_W-1:0] byte_in;
  logic                       is_bs, is_nl, bs_eff, plain;
  logic [led_pkg::CNT_W-1:0]  cnt_nxt, limit;
  logic                       end_nxt;

  logic [led_pkg::CNT_W-1:0]  count_q, rd_idx_q;
  logic [led_pkg::CAP_W-1:0]  cap_q;
  logic [1:0]                 echo_idx_q;
  logic                       end_q, any_q, triple_q, out_valid_q;
  logic [led_pkg::BYTE_W-1:0] byte_q;

  logic [led_pkg::KIND_W-1:0] kind_q;
  logic [led_pkg::BYTE_W-1:0] obyte_q;
  logic [led_pkg::LEN_W-1:0]  len_q;
  logic                       last_q;

  logic [led_pkg::BYTE_W-1:0] echo_byte, ram_rdata;
  logic                       echo_last, slot_free;

  assign byte_in = (rx_byte_i == led_pkg::CH_CR) ? led_pkg::CH_LF : rx_byte_i;
  assign is_bs   = (byte_in == led_pkg::CH_BS) || (byte_in == led_pkg::CH_DEL);
  assign is_nl   = (byte_in == led_pkg::CH_LF);
  assign bs_eff  = is_bs && (count_q != '0);
  assign plain   = !is_bs && !is_nl;

  always_comb begin
    cnt_nxt = count_q;
    if (bs_eff) begin
      cnt_nxt = count_q - 1'b1;
    end else if (plain) begin
      cnt_nxt = count_q + 1'b1;
    end
  end

  always_comb begin
    if (cap_q < led_pkg::CAP_MIN) begin
      limit = led_pkg::CNT_W'(led_pkg::CAP_MIN - 1'b1);
    end else if (cap_q > led_pkg::CAP_MAX) begin
      limit = led_pkg::CNT_W'(led_pkg::CAP_MAX - 1'b1);
    end else begin
      limit = led_pkg::CNT_W'(cap_q - 1'b1);
    end
  end

  assign end_nxt = is_nl || (cnt_nxt >= limit);

  assign echo_byte = triple_q ? ((echo_idx_q == 2'd1) ? led_pkg::CH_SP : led_pkg::CH_BS)
                              : byte_q;
  assign echo_last = triple_q ? (echo_idx_q == 2'd2) : 1'b1;
  assign slot_free = !out_valid_q || !out_stall_i;

  led_ram #(
    .WIDTH(led_pkg::BYTE_W),
    .DEPTH(led_pkg::BUF_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.accept && plain),
    .waddr_i(count_q),
    .wdata_i(byte_in),
    .re_i   (cmd_i.rd_issue),
    .raddr_i(rd_idx_q),
    .rdata_o(ram_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_idx_q    <= '0;
      cap_q       <= led_pkg::CAP_RESET;
      echo_idx_q  <= '0;
      end_q       <= 1'b0;
      any_q       <= 1'b0;
      triple_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        count_q    <= cnt_nxt;
        end_q      <= end_nxt;
        any_q      <= bs_eff || plain;
        triple_q   <= bs_eff;
        echo_idx_q <= '0;
        rd_idx_q   <= '0;
      end
      if (cmd_i.echo_emit) begin
        echo_idx_q <= echo_idx_q + 1'b1;
      end
      if (cmd_i.char_emit) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (cmd_i.done_emit) begin
        count_q <= '0;
      end
      if (cmd_i.echo_emit || cmd_i.char_emit || cmd_i.done_emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= byte_in;
    end
    if (cmd_i.echo_emit) begin
      kind_q  <= led_pkg::KIND_ECHO;
      obyte_q <= echo_byte;
      len_q   <= '0;
      last_q  <= echo_last && !end_q;
    end else if (cmd_i.char_emit) begin
      kind_q  <= led_pkg::KIND_CHAR;
      obyte_q <= ram_rdata;
      len_q   <= '0;
      last_q  <= 1'b0;
    end else if (cmd_i.done_emit) begin
      kind_q  <= led_pkg::KIND_DONE;
      obyte_q <= '0;
      len_q   <= led_pkg::LEN_W'(count_q);
      last_q  <= 1'b1;
    end
  end

  assign sts_o.slot_free = slot_free;
  assign sts_o.echo_any  = any_q;
  assign sts_o.echo_last = echo_last;
  assign sts_o.line_end  = end_q;
  assign sts_o.rd_done   = (rd_idx_q == count_q);

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = kind_q;
  assign out_byte_o    = obyte_q;
  assign line_length_o = len_q;
  assign last_of_run_o = last_q;

endmodule

FILE: hdl/line_editor_with_echo.sv
// first result: accept in IDLE, then DECIDE, then ECHO loads the output register;
// further echoes follow one per cycle while the output is not stalled
// line readout: each stored character is read (READ) and emitted (EMIT), then DONE emits the
// done result; input stalls while busy, a new byte is taken only in IDLE
// reset: count cleared, capacity 32, output empty; store contents undefined, no clearing pass
`timescale 1ns / 1ps

module line_editor_with_echo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [led_pkg::BYTE_W-1:0]     rx_byte_i,
  input  logic                           cfg_we_i,
  input  logic [led_pkg::CAP_W-1:0]      cfg_wdata_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [led_pkg::KIND_W-1:0]     out_kind_o,
  output logic [led_pkg::BYTE_W-1:0]     out_byte_o,
  output logic [led_pkg::LEN_W-1:0]      line_length_o,
  output logic                           last_of_run_o
);

  led_pkg::cmd_t cmd;
  led_pkg::sts_t sts;

  led_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  led_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_byte_i    (rx_byte_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_kind_o   (out_kind_o),
    .out_byte_o   (out_byte_o),
    .line_length_o(line_length_o),
    .last_of_run_o(last_of_run_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after transaction");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_kind_o <= led_pkg::KIND_DONE))
    else $error("illegal result kind");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_o == led_pkg::KIND_DONE) |-> (last_of_run_o && out_byte_o == '0))
    else $error("done result malformed");

  a_len_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_o != led_pkg::KIND_DONE) |-> (line_length_o == '0))
    else $error("length set on non-done result");

  a_char_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_o == led_pkg::KIND_CHAR) |-> !last_of_run_o)
    else $error("line character flagged last");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import led_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] ch;
    logic [LEN_W-1:0]  len;
    logic              last;
  } term_out_t;

  class line_scoreboard;
    logic [BYTE_W-1:0] line_mem [BUF_DEPTH];
    int                held;
    logic [CAP_W-1:0]  capacity;
    term_out_t         expected_out [$];
    int                errors;
    int                checked;
    int                lines_done;

    function new();
      held       = 0;
      capacity   = CAP_RESET;
      errors     = 0;
      checked    = 0;
      lines_done = 0;
    endfunction

    function void push_out(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] ch,
                           logic [LEN_W-1:0] len);
      term_out_t t;
      t.kind = kind;
      t.ch   = ch;
      t.len  = len;
      t.last = 1'b0;
      expected_out.push_back(t);
    endfunction

    function void note_rx(logic [BYTE_W-1:0] rx);
      logic [BYTE_W-1:0] c;
      int                lim;
      int                before_n;
      lim = int'(capacity);
      if (lim < int'(CAP_MIN)) lim = int'(CAP_MIN);
      if (lim > int'(CAP_MAX)) lim = int'(CAP_MAX);
      c = (rx == CH_CR) ? CH_LF : rx;
      before_n = expected_out.size();
      if (c == CH_BS || c == CH_DEL) begin
        if (held > 0) begin
          held--;
          push_out(KIND_ECHO, CH_BS, '0);
          push_out(KIND_ECHO, CH_SP, '0);
          push_out(KIND_ECHO, CH_BS, '0);
        end
      end else if (c != CH_LF) begin
        if (held < BUF_DEPTH) begin
          line_mem[held] = c;
          held++;
        end
        push_out(KIND_ECHO, c, '0);
      end
      if (c == CH_LF || held >= lim - 1) begin
        for (int i = 0; i < held; i++) push_out(KIND_CHAR, line_mem[i], '0);
        push_out(KIND_DONE, '0, LEN_W'(held));
        held = 0;
      end
      if (expected_out.size() > before_n) expected_out[$].last = 1'b1;
    endfunction

    function void check_out(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] ch,
                            logic [LEN_W-1:0] len, logic last);
      term_out_t e;
      if (expected_out.size() == 0) begin
        $error("output transaction with nothing expected: kind %0d byte %0d len %0d",
               kind, ch, len);
        errors++;
        return;
      end
      e = expected_out.pop_front();
      checked++;
      if (kind == KIND_DONE) lines_done++;
      if (kind !== e.kind) begin
        $error("out_kind: expected %0d, actual %0d", e.kind, kind);
        errors++;
      end
      if (ch !== e.ch) begin
        $error("out_byte: expected %0d, actual %0d", e.ch, ch);
        errors++;
      end
      if (len !== e.len) begin
        $error("line_length: expected %0d, actual %0d", e.len, len);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_of_run: expected %0d, actual %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  localparam int SETTLE_CYCLES = 20;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [BYTE_W-1:0] rx_byte_i;
  logic              cfg_we_i;
  logic [CAP_W-1:0]  cfg_wdata_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [KIND_W-1:0] out_kind_o;
  logic [BYTE_W-1:0] out_byte_o;
  logic [LEN_W-1:0]  line_length_o;
  logic              last_of_run_o;

  line_scoreboard sb = new();
  bit             gaps_on;
  int             rx_count;
  int             stall_left;

  line_editor_with_echo dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_kind_o    (out_kind_o),
    .out_byte_o    (out_byte_o),
    .line_length_o (line_length_o),
    .last_of_run_o (last_of_run_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    #4ms;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_out(out_kind_o, out_byte_o, line_length_o, last_of_run_o);
  end

  // receiver back-pressure in bursts
  initial begin
    out_stall_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i = 1'b1;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        stall_left  = $urandom_range(1, 13) - 1;
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_rx(b);
    rx_count++;
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      rx_byte_i  = BYTE_W'($urandom);
      gap = $urandom_range(1, 13);
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (sb.expected_out.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_idle();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = cap;
    sb.capacity = cap;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_rx();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6)  return CH_BS;
    if (r < 10) return CH_DEL;
    if (r < 14) return CH_LF;
    if (r < 17) return CH_CR;
    if (r < 27) return BYTE_W'($urandom_range(0, 255));
    return BYTE_W'($urandom_range(32, 126));
  endfunction

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int n, input bit fill_line);
    write_capacity(cap);
    if (fill_line) begin
      repeat (BUF_DEPTH - 1) send_byte(BYTE_W'($urandom_range(32, 126)));
    end
    repeat (n) send_byte(pick_rx());
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    gaps_on     = 1'b1;
    rx_count    = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty lines and edits on an empty line
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_BS);
    send_byte(CH_DEL);
    // field extremes, both erase codes, then a newline-terminated line
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h61);
    send_byte(CH_BS);
    send_byte(CH_DEL);
    send_byte(CH_LF);
    // line ends one character short of capacity, with clamped low capacities
    write_capacity(6'd3);
    send_byte(8'h78);
    send_byte(8'h79);
    write_capacity(6'd0);
    send_byte(8'h7A);
    write_capacity(6'd1);
    send_byte(8'h7E);
    // capacity lowered with a partial line held
    write_capacity(6'd32);
    send_byte(8'h61);
    send_byte(8'h62);
    send_byte(8'h63);
    send_byte(8'h64);
    write_capacity(6'd4);
    send_byte(CH_DEL);
    write_capacity(6'd33);
    send_byte(8'h65);
    send_byte(8'h66);
    send_byte(8'h67);
    write_capacity(6'd3);
    send_byte(8'h68);

    run_phase(6'd63, 5, 1'b1);
    run_phase(6'd2, 15, 1'b0);
    run_phase(6'($urandom_range(5, 30)), 20, 1'b0);
    run_phase(6'd32, 5, 1'b1);
    run_phase(6'd6, 15, 1'b0);
    run_phase(6'($urandom_range(0, 63)), 20, 1'b0);
    wait_idle();
    gaps_on = 1'b0;
    run_phase(6'd32, 10, 1'b0);
    send_byte(CH_LF);

    wait_idle();
    if (sb.expected_out.size() != 0) begin
      $error("%0d expected output transactions never arrived", sb.expected_out.size());
      sb.errors++;
    end
    $display("%0d received bytes over capacities 0 to 63, incl. erase, CR/LF and full lines",
             rx_count);
    $display("%0d output transactions checked, %0d lines completed", sb.checked,
             sb.lines_done);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/led_pkg.sv
hdl/led_ram.sv
hdl/led_ctrl.sv
hdl/led_dp.sv
hdl/line_editor_with_echo.sv
sim/tb_top.sv
